FILE: sv/b64e_pkg.sv
// Package for the base64 stream encoder: the job type passed from front to back,
// the character constants and the sextet-to-character mapping.
// No dependencies.
`default_nettype none

package b64e_pkg;

  localparam int unsigned JobQueueDepth = 2;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_UPPER = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_LOWER = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_DIGIT = 8'h30;  // '0'
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'

  // One group ready for output: four sextets, which of them print as pad,
  // and whether the group closes the message.
  typedef struct packed {
    logic [3:0][5:0] sextet;
    logic [3:0]      pad;
    logic            msg_end;
  } b64e_job_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] v8;
    logic [7:0] ch;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      ch = CHAR_UPPER + v8;
    end else if (v < 6'd52) begin
      ch = CHAR_LOWER + (v8 - 8'd26);
    end else if (v < 6'd62) begin
      ch = CHAR_DIGIT + (v8 - 8'd52);
    end else if (v == 6'd62) begin
      ch = CHAR_PLUS;
    end else begin
      ch = CHAR_SLASH;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: sv/b64e_if.sv
// Stream interfaces of the base64 encoder: raw bytes in, characters out.
// Valid/ready handshake; depends on nothing.
`default_nettype none

interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;
  logic       message_end;

  modport source (output valid, output out_char, output run_last, output message_end,
                  input ready);
  modport sink   (input valid, input out_char, input run_last, input message_end,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/b64e_front.sv
// Front end: accepts bytes, holds the pending bytes of a group and builds
// one output job per completed or final group. Uses b64e_pkg and b64e_in_if.
`default_nettype none

module b64e_front
  import b64e_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  b64e_in_if.sink     in_stream,
  input  wire logic   job_space,
  output logic        job_push,
  output b64e_job_t   job_data
);

  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  cnt_eff;
  logic        take;
  logic        emit;
  logic [7:0]  b;
  logic [15:0] pair;

  assign in_stream.ready = job_space;
  assign take            = in_stream.valid && job_space;
  assign b               = in_stream.data_byte;
  assign cnt_eff         = (cnt_r == 2'd3) ? 2'd0 : cnt_r;
  assign emit            = (cnt_eff == 2'd2) || in_stream.final_byte;
  assign pair            = {pend_r[7:0], b};
  assign job_push        = take && emit;

  always_comb begin
    job_data         = '0;
    job_data.msg_end = in_stream.final_byte;
    unique case (cnt_eff)
      2'd2: begin
        job_data.sextet[0] = pend_r[15:10];
        job_data.sextet[1] = {pend_r[9:8], pend_r[7:4]};
        job_data.sextet[2] = {pend_r[3:0], b[7:6]};
        job_data.sextet[3] = b[5:0];
        job_data.pad       = 4'b0000;
      end
      2'd1: begin
        job_data.sextet[0] = pair[15:10];
        job_data.sextet[1] = pair[9:4];
        job_data.sextet[2] = {pair[3:0], 2'b00};
        job_data.pad       = 4'b1000;
      end
      default: begin
        job_data.sextet[0] = b[7:2];
        job_data.sextet[1] = {b[1:0], 4'b0000};
        job_data.pad       = 4'b1100;
      end
    endcase
  end

  always_comb begin
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    if (take) begin
      if (emit) begin
        pend_nxt = '0;
        cnt_nxt  = 2'd0;
      end else begin
        pend_nxt = {pend_r[7:0], b};
        cnt_nxt  = cnt_eff + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      cnt_r  <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("pending count out of range");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |=> (cnt_r == 2'd0 && pend_r == 16'd0))
    else $error("pending bytes not cleared after a group was emitted");

endmodule

`default_nettype wire

FILE: sv/b64e_fifo.sv
// Short job queue between front and back end, flip-flop storage.
// Uses b64e_pkg for the job type.
`default_nettype none

module b64e_fifo
  import b64e_pkg::*;
#(
  parameter int unsigned DEPTH = JobQueueDepth
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire b64e_job_t  push_data,
  output logic            space,
  input  wire logic       pop,
  output logic            avail,
  output b64e_job_t       pop_data
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  b64e_job_t           mem_r [DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     count_r, count_nxt;
  logic                do_push, do_pop;

  assign space    = (count_r != CntW'(DEPTH));
  assign avail    = (count_r != '0);
  assign do_push  = push && space;
  assign do_pop   = pop && avail;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !space))
    else $error("job pushed into a full queue");

endmodule

`default_nettype wire

FILE: sv/b64e_back.sv
// Back end: takes one job at a time from the queue and sends its four
// characters through a registered output stage. Uses b64e_pkg and b64e_out_if.
`default_nettype none

module b64e_back
  import b64e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       job_avail,
  input  wire b64e_job_t  job_data,
  output logic            job_pop,
  b64e_out_if.source      out_stream
);

  b64e_job_t  job_r;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r;
  logic       run_last_r;
  logic       msg_end_r;
  logic       adv;
  logic       last_char;
  logic       load;
  logic [7:0] cur_char;

  assign adv       = busy_r && (!out_valid_r || out_stream.ready);
  assign last_char = (idx_r == 2'd3);
  assign load      = job_avail && (!busy_r || (adv && last_char));
  assign job_pop   = load;
  assign cur_char  = job_r.pad[idx_r] ? PAD_CHAR : sextet_char(job_r.sextet[idx_r]);

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      idx_nxt       = idx_r + 2'd1;
      out_valid_nxt = 1'b1;
      if (last_char) begin
        busy_nxt = 1'b0;
      end
    end else if (out_stream.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: hold the current job, latch each character as it advances
  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job_data;
    end
    if (adv) begin
      out_char_r <= cur_char;
      run_last_r <= last_char;
      msg_end_r  <= last_char && job_r.msg_end;
    end
  end

  assign out_stream.valid       = out_valid_r;
  assign out_stream.out_char    = out_char_r;
  assign out_stream.run_last    = run_last_r;
  assign out_stream.message_end = msg_end_r;

  a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && msg_end_r) |-> run_last_r)
    else $error("message end flagged on a character that does not close its run");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |=> (idx_r == 2'd0 || $stable(idx_r)))
    else $error("character index moved while no job was active");

endmodule

`default_nettype wire

FILE: sv/base64_stream_encoder_core.sv
// Base64 stream encoder (standard alphabet, '=' padding).
//
// in_stream  : one raw byte per request (data_byte) with final_byte set on the
//              last byte of a message. A message holds at least one byte.
// out_stream : one ASCII character per request; run_last marks the last
//              character caused by an input byte, message_end the last character
//              of the whole message.
//
// Bytes one and two of a group are held in the front end and cause no output.
// The third byte, or a final byte, turns the group into a job of four
// characters ('=' padded for a short tail) that enters a job queue of
// JOB_DEPTH entries. The back end drains one character per cycle while the
// receiver is ready, and loads the next job as the last character of a job
// advances; a byte is accepted every cycle while the queue has room.
// With queue and output empty, the job of a completing byte passes through
// the queue storage, the back end's job register, then the output register.
// When the receiver stalls, the output register holds its character, the back
// end stops, the queue fills and in_stream.ready drops.
// Reset clears the pending bytes, the queue and the output valid flag.
`default_nettype none

module base64_stream_encoder_core
  import b64e_pkg::*;
#(
  parameter int unsigned JOB_DEPTH = JobQueueDepth
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  b64e_in_if.sink      in_stream,
  b64e_out_if.source   out_stream
);

  b64e_job_t push_job;
  b64e_job_t pop_job;
  logic      push;
  logic      space;
  logic      pop;
  logic      avail;

  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_stream),
    .job_space (space),
    .job_push  (push),
    .job_data  (push_job)
  );

  b64e_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_job),
    .space     (space),
    .pop       (pop),
    .avail     (avail),
    .pop_data  (pop_job)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_avail  (avail),
    .job_data   (pop_job),
    .job_pop    (pop),
    .out_stream (out_stream)
  );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking bench for base64_stream_encoder_core: a table of directed bytes, then
// random messages, with gaps on both sides; every character is checked in order.
// Depends on b64e_pkg, the b64e_in_if / b64e_out_if interfaces and the core.
`timescale 1ns / 1ps

module testbench;
  import b64e_pkg::*;

  localparam int ITEM_TARGET = 460;
  localparam int IDLE_LIMIT  = 1000;
  localparam int DRAIN_WAIT  = 20;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       msg_end;
  } b64_char_t;

  // lit holds four typed characters; typed = 0 leaves the row to the encoder model
  typedef struct packed {
    logic [7:0]  data;
    logic        fin;
    logic        typed;
    logic [31:0] lit;
  } dir_row_t;

  localparam int NUM_ROWS = 22;

  logic clk;
  logic rst_n;

  b64e_in_if  in_ch ();
  b64e_out_if out_ch ();

  base64_stream_encoder_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_ch),
    .out_stream(out_ch)
  );

  string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  dir_row_t dir_rows [NUM_ROWS] = '{
    {8'h00, 1'b1, 1'b1, "AA=="},  // lone final byte, all zero
    {8'hFF, 1'b1, 1'b1, "/w=="},  // lone final byte, all ones
    {8'h4D, 1'b0, 1'b0, 32'h0},
    {8'h61, 1'b1, 1'b1, "TWE="},  // final byte second in group
    {8'h4D, 1'b0, 1'b0, 32'h0},
    {8'h61, 1'b0, 1'b0, 32'h0},
    {8'h6E, 1'b0, 1'b1, "TWFu"},  // full group, message goes on
    {8'h00, 1'b1, 1'b1, "AA=="},
    {8'hFF, 1'b0, 1'b0, 32'h0},
    {8'hFF, 1'b0, 1'b0, 32'h0},
    {8'hFF, 1'b1, 1'b1, "////"},  // final byte completes group
    {8'h00, 1'b0, 1'b0, 32'h0},
    {8'h00, 1'b0, 1'b0, 32'h0},
    {8'h00, 1'b1, 1'b1, "AAAA"},
    {8'hFB, 1'b0, 1'b0, 32'h0},
    {8'hFF, 1'b1, 1'b1, "+/8="},  // '+' and '/' in a short tail
    {8'h01, 1'b0, 1'b0, 32'h0},
    {8'h80, 1'b1, 1'b0, 32'h0},
    {8'h12, 1'b0, 1'b0, 32'h0},
    {8'h34, 1'b0, 1'b0, 32'h0},
    {8'h56, 1'b0, 1'b0, 32'h0},
    {8'h78, 1'b1, 1'b0, 32'h0}
  };

  // Encoder model state
  logic [15:0] held_bytes;
  logic [1:0]  held_count;
  b64_char_t   next_chars [4];

  b64_char_t char_queue [$];

  int err_count     = 0;
  int byte_count    = 0;
  int msg_count     = 0;
  int chars_checked = 0;
  int idle_cycles   = 0;

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("%0t ns mismatch: %s got %0h want %0h", $time, what, got, want);
    end
  endtask

  // Mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the model by one byte; fill next_chars and return how many came out
  function automatic int encode_step(input logic [7:0] b, input logic f);
    logic [1:0]  cnt;
    logic [23:0] grp;
    logic [5:0]  sx;
    int          npad;
    cnt = (held_count == 2'd3) ? 2'd0 : held_count;
    if (cnt == 2'd2) begin
      grp  = {held_bytes, b};
      npad = 0;
    end else if (!f) begin
      held_bytes = {held_bytes[7:0], b};
      held_count = cnt + 2'd1;
      return 0;
    end else if (cnt == 2'd0) begin
      grp  = {b, 16'h0000};
      npad = 2;
    end else begin
      grp  = {held_bytes[7:0], b, 8'h00};
      npad = 1;
    end
    for (int k = 0; k < 4; k++) begin
      sx = grp[23 - 6 * k -: 6];
      next_chars[k].ch       = (k < 4 - npad) ? b64_alphabet.getc(int'(sx)) : PAD_CHAR;
      next_chars[k].run_last = (k == 3);
      next_chars[k].msg_end  = (k == 3) && f;
    end
    held_bytes = '0;
    held_count = '0;
    return 4;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic f, input bit no_gaps,
                           input bit use_lit, input logic [31:0] lit);
    int        gap;
    int        n;
    b64_char_t c;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.final_byte <= f;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n = encode_step(b, f);
    for (int k = 0; k < n; k++) begin
      if (use_lit) begin
        c.ch       = lit[31 - 8 * k -: 8];
        c.run_last = (k == 3);
        c.msg_end  = (k == 3) && f;
      end else begin
        c = next_chars[k];
      end
      char_queue.push_back(c);
    end
    byte_count++;
    if (f) msg_count++;
  endtask

  // Drop valid and hold the sender until every pending character is out
  task automatic wait_for_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (char_queue.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls plus occasional stall-free stretches
  initial begin
    int   hold_cnt;
    int   n;
    logic rdy;
    hold_cnt     = 0;
    rdy          = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
      end else if ($urandom_range(0, 99) < 4) begin
        rdy      = 1'b1;
        hold_cnt = $urandom_range(30, 120);
      end else begin
        n        = pick_gap();
        rdy      = (n == 0);
        hold_cnt = (n > 0) ? n - 1 : 0;
      end
      out_ch.ready <= rdy;
    end
  end

  always @(posedge clk) begin
    b64_char_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (char_queue.size() == 0) begin
        report_mismatch("unexpected character", int'(out_ch.out_char), 0);
      end else begin
        want = char_queue.pop_front();
        if (out_ch.out_char !== want.ch)
          report_mismatch("out_char", int'(out_ch.out_char), int'(want.ch));
        if (out_ch.run_last !== want.run_last)
          report_mismatch("run_last", int'(out_ch.run_last), int'(want.run_last));
        if (out_ch.message_end !== want.msg_end)
          report_mismatch("message_end", int'(out_ch.message_end), int'(want.msg_end));
        chars_checked++;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no request moved for %0d cycles, %0d characters outstanding",
               IDLE_LIMIT, char_queue.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int  msg_len;
    int  r;
    bit  no_gaps;
    bit  paused_mid;
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.final_byte = 1'b0;
    held_bytes       = '0;
    held_count       = '0;
    paused_mid       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      send_byte(dir_rows[i].data, dir_rows[i].fin, 1'b0, dir_rows[i].typed, dir_rows[i].lit);
    end

    while (byte_count < ITEM_TARGET) begin
      r       = $urandom_range(0, 99);
      msg_len = (r < 70) ? $urandom_range(1, 6) :
                (r < 95) ? $urandom_range(7, 15) : $urandom_range(16, 40);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < msg_len; j++) begin
        send_byte(8'($urandom_range(0, 255)), (j == msg_len - 1), no_gaps, 1'b0, 32'h0);
      end
      if ((!paused_mid && byte_count >= ITEM_TARGET / 2) || $urandom_range(0, 19) == 0) begin
        paused_mid = 1'b1;
        wait_for_drain();
      end
    end

    wait_for_drain();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d messages, %0d bytes, %0d characters checked in order",
             msg_count, byte_count, chars_checked);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", err_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/b64e_pkg.sv
sv/b64e_if.sv
sv/b64e_front.sv
sv/b64e_fifo.sv
sv/b64e_back.sv
sv/base64_stream_encoder_core.sv
tb/testbench.sv
